>>> design/bstk_pkg.sv
// Shared types and constants for the bounded stack core.
// Holds the command and status codes and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bstk_pkg;

  localparam int unsigned DEPTH_DEF      = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned CMD_W          = 3;
  localparam int unsigned POS_W          = 7;
  localparam int unsigned CAP_W          = 7;
  localparam int unsigned IO_DATA_W      = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_CHANGE  = 3'd3,
    CMD_DISPLAY = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic    lat_in;
    logic    push_wr;
    logic    chg_wr;
    logic    rd_first;
    logic    rd_next;
    logic    pop_dec;
    logic    ld_out;
    status_t out_status;
    logic    out_use_mem;
    logic    out_last;
  } dp_ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic push_ovf;
    logic empty;
    logic pos_bad;
    logic disp_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> design/bstk_ctrl.sv
// Controller state machine for the bounded stack core.
// Drives datapath commands from datapath status; depends on bstk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bstk_ctrl
  import bstk_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire dp_sts_t sts,
  output dp_ctl_t      ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    ctl.out_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.lat_in = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.cmd)
          CMD_PUSH: begin
            if (sts.out_free) begin
              ctl.ld_out     = 1'b1;
              ctl.out_last   = 1'b1;
              ctl.out_status = sts.push_ovf ? ST_OVERFLOW : ST_OK;
              ctl.push_wr    = !sts.push_ovf;
              state_nxt      = S_IDLE;
            end
          end
          CMD_POP: begin
            if (sts.empty) begin
              if (sts.out_free) begin
                ctl.ld_out     = 1'b1;
                ctl.out_last   = 1'b1;
                ctl.out_status = ST_UNDERFLOW;
                state_nxt      = S_IDLE;
              end
            end else begin
              ctl.rd_first = 1'b1;
              state_nxt    = S_RESP;
            end
          end
          CMD_PEEK, CMD_CHANGE: begin
            if (sts.pos_bad) begin
              if (sts.out_free) begin
                ctl.ld_out     = 1'b1;
                ctl.out_last   = 1'b1;
                ctl.out_status = ST_UNDERFLOW;
                state_nxt      = S_IDLE;
              end
            end else begin
              ctl.rd_first = 1'b1;
              state_nxt    = S_RESP;
            end
          end
          CMD_DISPLAY: begin
            if (sts.empty) begin
              if (sts.out_free) begin
                ctl.ld_out     = 1'b1;
                ctl.out_last   = 1'b1;
                ctl.out_status = ST_EMPTY;
                state_nxt      = S_IDLE;
              end
            end else begin
              ctl.rd_first = 1'b1;
              state_nxt    = S_RESP;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_RESP: begin
        if (sts.out_free) begin
          ctl.ld_out      = 1'b1;
          ctl.out_use_mem = 1'b1;
          ctl.out_status  = ST_OK;
          ctl.pop_dec     = (sts.cmd == CMD_POP);
          ctl.chg_wr      = (sts.cmd == CMD_CHANGE);
          if ((sts.cmd == CMD_DISPLAY) && !sts.disp_last) begin
            ctl.rd_next  = 1'b1;
            ctl.out_last = 1'b0;
          end else begin
            ctl.out_last = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/bstk_dp.sv
// Datapath for the bounded stack core: stack memory, entry count, capacity
// register, latched command and the result register. Depends on bstk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bstk_dp
  import bstk_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [CMD_W-1:0]            in_command,
  input  wire logic signed [IO_DATA_W-1:0] in_value,
  input  wire logic [POS_W-1:0]            in_position,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_status,
  output logic signed [IO_DATA_W-1:0]      out_data,
  output logic                             out_last,
  input  wire logic                        cfg_wr_en,
  input  wire logic [CAP_W-1:0]            cfg_wr_data,
  input  wire dp_ctl_t                     ctl,
  output dp_sts_t                          sts
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CAP_W-1:0] DEPTH_CAP = CAP_W'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [CMD_W-1:0]            cmd_r;
  logic signed [IO_DATA_W-1:0] value_r;
  logic [POS_W-1:0]            position_r;
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;
  logic [CAP_W-1:0]            cap_r;
  logic [AW-1:0]               addr_r;
  logic [AW-1:0]               addr_nxt;
  logic [DATA_WIDTH-1:0]       rdata_r;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [1:0]                  out_status_r;
  logic signed [IO_DATA_W-1:0] out_data_r;
  logic                        out_last_r;

  logic [CAP_W-1:0]      cap_eff;
  logic [POS_W-1:0]      count_ext;
  logic [POS_W-1:0]      pos_diff;
  logic [CNT_W-1:0]      top_idx;
  logic [AW-1:0]         first_addr;
  logic                  rd_en;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [63:0]           val_ext;
  logic [63:0]           rd_ext;
  logic [DATA_WIDTH-1:0] wdata;

  assign cap_eff   = (cap_r > DEPTH_CAP) ? DEPTH_CAP : cap_r;
  assign count_ext = POS_W'(count_r);
  assign pos_diff  = count_ext - position_r;
  assign top_idx   = count_r - CNT_W'(1);
  assign first_addr = ((cmd_r == CMD_PEEK) || (cmd_r == CMD_CHANGE)) ?
                      pos_diff[AW-1:0] : top_idx[AW-1:0];

  assign rd_en    = ctl.rd_first | ctl.rd_next;
  assign addr_nxt = ctl.rd_first ? first_addr : (addr_r - AW'(1));

  assign wr_en   = ctl.push_wr | ctl.chg_wr;
  assign wr_addr = ctl.push_wr ? count_r[AW-1:0] : addr_r;
  assign val_ext = 64'(signed'(value_r));
  assign wdata   = val_ext[DATA_WIDTH-1:0];
  assign rd_ext  = 64'(signed'(rdata_r));

  assign sts.cmd       = cmd_t'(cmd_r);
  assign sts.push_ovf  = (CAP_W'(count_r) >= cap_eff);
  assign sts.empty     = (count_r == '0);
  assign sts.pos_bad   = (position_r == '0) || (position_r > count_ext);
  assign sts.disp_last = (addr_r == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    count_nxt = count_r;
    if (ctl.push_wr) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.pop_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.lat_in) begin
      cmd_r      <= in_command;
      value_r    <= in_value;
      position_r <= in_position;
    end
    if (rd_en) begin
      addr_r <= addr_nxt;
    end
    if (ctl.ld_out) begin
      out_status_r <= ctl.out_status;
      out_data_r   <= ctl.out_use_mem ? signed'(rd_ext[IO_DATA_W-1:0]) : '0;
      out_last_r   <= ctl.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[addr_nxt];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

>>> design/bounded_stack_with_peek_and_change_core.sv
// Top level of the bounded stack core with peek and change.
// Joins bstk_ctrl and bstk_dp; depends on bstk_pkg.
//
//   Channel  Direction  Handshake           Contents
//   in_      input      in_valid/in_stall   command, value, position
//   out_     output     out_valid/out_stall status, data, last
//   cfg_     input      cfg_wr_en           capacity
//
// Push and every error result go into the result register from the execute state.
// Pop, peek and change go on to the response state for the registered memory read.
// Display gives one result per cycle after the first read unless stalled, one per entry.
// Reset is synchronous, clears the count and the result valid flag, sets capacity to 64.
// A stalled result register holds the controller; a new input transfer is taken
// while a finished result still waits, once the previous command is done.
`timescale 1ns / 1ps
`default_nettype none

module bounded_stack_with_peek_and_change_core
  import bstk_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [CMD_W-1:0]            in_command,
  input  wire logic signed [IO_DATA_W-1:0] in_value,
  input  wire logic [POS_W-1:0]            in_position,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_status,
  output logic signed [IO_DATA_W-1:0]      out_data,
  output logic                             out_last,
  input  wire logic                        cfg_wr_en,
  input  wire logic [CAP_W-1:0]            cfg_wr_data
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  bstk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  bstk_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_command  (in_command),
    .in_value    (in_value),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_data    (out_data),
    .out_last    (out_last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl),
    .sts         (sts)
  );

endmodule

`default_nettype wire

>>> tb/bounded_stack_with_peek_and_change_core_test.sv
// Self-checking testbench for bounded_stack_with_peek_and_change_core: a mirror stack predicts every
// reply and a monitor checks each out_ transfer against it, under random gaps and stalls.
// Depends on bstk_pkg and the core RTL only.
`timescale 1ns / 1ps

module bounded_stack_with_peek_and_change_core_test;
  import bstk_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct {
    logic [CMD_W-1:0]            command;
    logic signed [IO_DATA_W-1:0] value;
    logic [POS_W-1:0]            position;
  } stack_cmd_t;

  typedef struct {
    status_t                     status;
    logic signed [IO_DATA_W-1:0] data;
    logic                        last;
  } stack_reply_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [CMD_W-1:0]            in_command = '0;
  logic signed [IO_DATA_W-1:0] in_value = '0;
  logic [POS_W-1:0]            in_position = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [1:0]                  out_status;
  logic signed [IO_DATA_W-1:0] out_data;
  logic                        out_last;
  logic                        cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]            cfg_wr_data = '0;

  stack_cmd_t   cmd_q[$];
  stack_reply_t awaited_q[$];
  stack_cmd_t   presented_cmd;

  logic signed [IO_DATA_W-1:0] stack_mirror [DEPTH_DEF];
  int unsigned mirror_count = 0;
  int unsigned mirror_cap = CAP_RESET;

  int unsigned fail_count = 0;
  int unsigned gap_hold = 0;
  int unsigned stall_hold = 0;
  logic        calm = 1'b0;

  bounded_stack_with_peek_and_change_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_command  (in_command),
    .in_value    (in_value),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_data    (out_data),
    .out_last    (out_last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_reply(input status_t status, input logic signed [IO_DATA_W-1:0] data,
                           input logic last);
    stack_reply_t r;
    r.status = status;
    r.data   = data;
    r.last   = last;
    awaited_q.push_back(r);
  endtask

  task automatic apply_stack_command(input stack_cmd_t c);
    int unsigned eff_cap;
    int unsigned idx;
    int unsigned k;
    eff_cap = (mirror_cap > DEPTH_DEF) ? DEPTH_DEF : mirror_cap;
    case (c.command)
      CMD_PUSH: begin
        if (mirror_count >= eff_cap) begin
          add_reply(ST_OVERFLOW, '0, 1'b1);
        end else begin
          stack_mirror[mirror_count] = c.value;
          mirror_count++;
          add_reply(ST_OK, '0, 1'b1);
        end
      end
      CMD_POP: begin
        if (mirror_count == 0) begin
          add_reply(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          mirror_count--;
          add_reply(ST_OK, stack_mirror[mirror_count], 1'b1);
        end
      end
      CMD_PEEK, CMD_CHANGE: begin
        if (c.position == 0 || c.position > mirror_count) begin
          add_reply(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          idx = mirror_count - c.position;
          add_reply(ST_OK, stack_mirror[idx], 1'b1);
          if (c.command == CMD_CHANGE) stack_mirror[idx] = c.value;
        end
      end
      CMD_DISPLAY: begin
        if (mirror_count == 0) begin
          add_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          for (k = 0; k < mirror_count; k++)
            add_reply(ST_OK, stack_mirror[mirror_count - 1 - k], k + 1 == mirror_count);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_stack_command(presented_cmd);
      if (!in_valid || !in_stall) begin
        if (gap_hold != 0) begin
          gap_hold <= gap_hold - 1;
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          presented_cmd = cmd_q.pop_front();
          in_valid    <= 1'b1;
          in_command  <= presented_cmd.command;
          in_value    <= presented_cmd.value;
          in_position <= presented_cmd.position;
          gap_hold    <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : stall_gen
    int unsigned g;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (out_stall) begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 6);
    end else begin
      g = gap_len();
      out_stall  <= (g != 0);
      stall_hold <= (g != 0) ? g - 1 : 0;
    end
  end

  always @(posedge clk) begin : result_check
    stack_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_q.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, actual status %0d data %0d last %0b",
                 $time, out_status, out_data, out_last);
        fail_count++;
      end else begin
        want = awaited_q.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status,
                   out_status);
          fail_count++;
        end
        if (out_data !== want.data) begin
          $display("%0t: data mismatch: expected %0d, actual %0d", $time, want.data, out_data);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  task automatic queue_cmd(input logic [CMD_W-1:0] command,
                           input logic signed [IO_DATA_W-1:0] value,
                           input logic [POS_W-1:0] position);
    stack_cmd_t c;
    c.command  = command;
    c.value    = value;
    c.position = position;
    cmd_q.push_back(c);
  endtask

  function automatic logic signed [IO_DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return -1;
      2: return 32'sh7FFF_FFFF;
      3: return 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_cmds(input int unsigned n);
    int unsigned made;
    int unsigned cnt;
    int unsigned eff_cap;
    int unsigned r;
    int unsigned push_w;
    int unsigned pop_w;
    logic [POS_W-1:0] pos;
    made = 0;
    cnt = mirror_count;
    eff_cap = (mirror_cap > DEPTH_DEF) ? DEPTH_DEF : mirror_cap;
    while (made < n) begin
      r = $urandom_range(0, 99);
      push_w = (cnt >= eff_cap) ? 10 : 35;
      pop_w  = (cnt > eff_cap) ? 40 : 20;
      if (cnt > 0 && $urandom_range(0, 3) != 0) begin
        pos = POS_W'($urandom_range(1, cnt));
      end else begin
        case ($urandom_range(0, 2))
          0: pos = '0;
          1: pos = POS_W'(cnt + 1);
          default: pos = POS_W'($urandom_range(0, 127));
        endcase
      end
      if (r < push_w) begin
        queue_cmd(CMD_PUSH, pick_value(), POS_W'($urandom_range(0, 127)));
        if (cnt < eff_cap) cnt++;
        made++;
      end else if (r < push_w + pop_w) begin
        queue_cmd(CMD_POP, pick_value(), POS_W'($urandom_range(0, 127)));
        if (cnt > 0) cnt--;
        made++;
      end else if (r < push_w + pop_w + 15) begin
        queue_cmd(CMD_PEEK, pick_value(), pos);
        made++;
      end else if (r < 80) begin
        queue_cmd(CMD_CHANGE, pick_value(), pos);
        made++;
      end else if (r < 95) begin
        queue_cmd(CMD_DISPLAY, pick_value(), POS_W'($urandom_range(0, 127)));
        made++;
      end else begin
        queue_cmd(CMD_W'($urandom_range(CMD_RSVD_5, CMD_RSVD_7)), pick_value(),
                  POS_W'($urandom_range(0, 127)));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (cmd_q.size() != 0 || in_valid || awaited_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reprogram_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    mirror_cap = cap;
    calm = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    reprogram_capacity(7'd3);
    queue_cmd(CMD_POP, 0, 0);
    queue_cmd(CMD_DISPLAY, 0, 0);
    queue_cmd(CMD_PEEK, 0, 0);
    queue_cmd(CMD_CHANGE, 5, 1);
    queue_cmd(CMD_PUSH, 32'sh7FFF_FFFF, 0);
    queue_cmd(CMD_PUSH, 32'sh8000_0000, 127);
    queue_cmd(CMD_PUSH, -1, 0);
    queue_cmd(CMD_PUSH, 0, 0);
    queue_cmd(CMD_DISPLAY, 0, 0);
    queue_cmd(CMD_PEEK, 0, 1);
    queue_cmd(CMD_PEEK, 0, 3);
    queue_cmd(CMD_PEEK, 0, 4);
    queue_cmd(CMD_PEEK, 0, 0);
    queue_cmd(CMD_PEEK, 0, 127);
    queue_cmd(CMD_CHANGE, 32'sh5A5A_5A5A, 2);
    queue_cmd(CMD_CHANGE, 1, 0);
    queue_cmd(CMD_CHANGE, 2, 4);
    queue_cmd(CMD_RSVD_5, 3, 1);
    queue_cmd(CMD_RSVD_6, 3, 1);
    queue_cmd(CMD_RSVD_7, -1, 127);
    queue_cmd(CMD_DISPLAY, 0, 0);
    queue_cmd(CMD_POP, 0, 0);
    queue_cmd(CMD_PEEK, 0, 2);

    // Capacity now sits below the number of stored entries.
    reprogram_capacity(7'd1);
    queue_cmd(CMD_PUSH, 11, 0);
    queue_cmd(CMD_DISPLAY, 0, 0);
    queue_cmd(CMD_PEEK, 0, 2);
    queue_cmd(CMD_CHANGE, 7, 1);
    queue_cmd(CMD_POP, 0, 0);
    queue_cmd(CMD_PUSH, 12, 0);
    queue_cmd(CMD_POP, 0, 0);
    queue_cmd(CMD_POP, 0, 0);
    queue_cmd(CMD_PUSH, 9, 0);
    queue_cmd(CMD_POP, 0, 0);

    reprogram_capacity(7'd0);
    queue_cmd(CMD_PUSH, 13, 0);
    queue_cmd(CMD_DISPLAY, 0, 0);
    queue_cmd(CMD_POP, 0, 0);

    // Capacity above the depth: fill the whole store, overflow once, then list it all.
    reprogram_capacity(7'd127);
    repeat (DEPTH_DEF - mirror_count + 1)
      queue_cmd(CMD_PUSH, pick_value(), POS_W'($urandom_range(0, 127)));
    queue_cmd(CMD_DISPLAY, 0, 0);
    queue_random_cmds(2);

    reprogram_capacity(7'd64);
    queue_random_cmds(2);
    reprogram_capacity(CAP_W'($urandom_range(2, 8)));
    queue_random_cmds(2);
    reprogram_capacity(CAP_W'($urandom_range(65, 126)));
    queue_random_cmds(2);
    reprogram_capacity(CAP_W'($urandom_range(1, 64)));
    queue_random_cmds(2);

    wait_drained();
    if (fail_count == 0 && awaited_q.size() == 0) begin
      $display("** bounded_stack_with_peek_and_change_core: PASSED **");
    end else begin
      $display("** bounded_stack_with_peek_and_change_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("** bounded_stack_with_peek_and_change_core: FAILED **");
    $finish;
  end

endmodule

>>> files.f
design/bstk_pkg.sv
design/bstk_ctrl.sv
design/bstk_dp.sv
design/bounded_stack_with_peek_and_change_core.sv
tb/bounded_stack_with_peek_and_change_core_test.sv
